// ===== sv/afvsp_pkg.sv =====
// Shared types, codes and tables of the four-voice ADPCM sample player.
`timescale 1ns / 1ps
package afvsp_pkg;

  localparam int unsigned ROM_ADDR_BITS_DEF = 18;
  localparam int unsigned VOICES_DEF        = 4;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_CMD   = 2'd1;
  localparam logic [1:0] REQ_ROM   = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [7:0] CFG_MASTER_VOLUME = 8'd0;
  localparam logic [7:0] CFG_SAMPLE_STEP   = 8'd1;

  localparam logic [9:0]  MASTER_VOLUME_RST = 10'd256;
  localparam logic [15:0] SAMPLE_STEP_RST   = 16'd4096;
  localparam logic [16:0] ONE_STEP          = 17'h01000;
  localparam logic [18:0] SPAN_LIMIT        = 19'h7ffff;

  localparam logic signed [13:0] LVL_MAX = 14'sd2047;
  localparam logic signed [13:0] LVL_MIN = -14'sd2048;
  localparam logic signed [6:0]  IDX_MAX = 7'sd48;
  localparam logic signed [23:0] OUT_MAX = 24'sh007fff;
  localparam logic signed [23:0] OUT_MIN = -24'sh008000;

  localparam int unsigned MIX_W = 18;
  localparam int unsigned POS_W = 19;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  rem;
    logic [5:0]        sidx;
    logic signed [11:0] lvl;
    logic [7:0]        latch;
    logic [8:0]        gain;
  } voice_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] prev;
    logic signed [MIX_W-1:0] cur;
    logic [11:0]             frac;
    logic [9:0]              mvol;
  } interp_req_t;

  function automatic logic [10:0] step_size(input logic [5:0] idx);
    logic [10:0] r;
    unique case (idx)
      6'd0: r = 11'd16;    6'd1: r = 11'd17;    6'd2: r = 11'd19;    6'd3: r = 11'd21;
      6'd4: r = 11'd23;    6'd5: r = 11'd25;    6'd6: r = 11'd28;    6'd7: r = 11'd31;
      6'd8: r = 11'd34;    6'd9: r = 11'd37;    6'd10: r = 11'd41;   6'd11: r = 11'd45;
      6'd12: r = 11'd50;   6'd13: r = 11'd55;   6'd14: r = 11'd60;   6'd15: r = 11'd66;
      6'd16: r = 11'd73;   6'd17: r = 11'd80;   6'd18: r = 11'd88;   6'd19: r = 11'd97;
      6'd20: r = 11'd107;  6'd21: r = 11'd118;  6'd22: r = 11'd130;  6'd23: r = 11'd143;
      6'd24: r = 11'd157;  6'd25: r = 11'd173;  6'd26: r = 11'd190;  6'd27: r = 11'd209;
      6'd28: r = 11'd230;  6'd29: r = 11'd253;  6'd30: r = 11'd279;  6'd31: r = 11'd307;
      6'd32: r = 11'd337;  6'd33: r = 11'd371;  6'd34: r = 11'd408;  6'd35: r = 11'd449;
      6'd36: r = 11'd494;  6'd37: r = 11'd544;  6'd38: r = 11'd598;  6'd39: r = 11'd658;
      6'd40: r = 11'd724;  6'd41: r = 11'd796;  6'd42: r = 11'd876;  6'd43: r = 11'd963;
      6'd44: r = 11'd1060; 6'd45: r = 11'd1166; 6'd46: r = 11'd1282; 6'd47: r = 11'd1411;
      6'd48: r = 11'd1552;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [4:0] step_adjust(input logic [2:0] code);
    logic signed [4:0] r;
    unique case (code)
      3'd4: r = 5'sd2;
      3'd5: r = 5'sd4;
      3'd6: r = 5'sd6;
      3'd7: r = 5'sd8;
      default: r = -5'sd1;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] gain_lut(input logic [3:0] vol);
    logic [8:0] r;
    unique case (vol)
      4'd0: r = 9'd256;  4'd1: r = 9'd181;  4'd2: r = 9'd128;  4'd3: r = 9'd91;
      4'd4: r = 9'd64;   4'd5: r = 9'd46;   4'd6: r = 9'd32;   4'd7: r = 9'd23;
      4'd8: r = 9'd16;   4'd9: r = 9'd11;   4'd10: r = 9'd8;   4'd11: r = 9'd6;
      4'd12: r = 9'd4;   4'd13: r = 9'd3;   4'd14: r = 9'd2;   default: r = 9'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/afvsp_if.sv =====
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
interface afvsp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  cmd_byte;
  logic [17:0] rom_addr;
  logic [7:0]  rom_byte;
  modport source (output valid, req_type, cmd_byte, rom_addr, rom_byte, input ready);
  modport sink (input valid, req_type, cmd_byte, rom_addr, rom_byte, output ready);
endinterface

interface afvsp_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] audio_sample;
  logic [3:0]         voice_active;
  modport source (output valid, audio_sample, voice_active, input ready);
  modport sink (input valid, audio_sample, voice_active, output ready);
endinterface

interface afvsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/adpcm_four_voice_sample_player_core.sv =====
// Top level: request sequencer, sample ROM and voice state memories.
//
// Usage: requests enter on req_i (tick, command byte or ROM byte write);
// every request yields exactly one result on res_o carrying the audio sample
// (zero except for ticks) and the active voice mask after the request.
// cfg_i writes master volume (index 0) and sample step (index 1) whenever its
// valid is high; it is always ready and is meant to be written when idle.
// One request is processed at a time. ROM writes, stop commands and the
// first start byte go from idle straight to the done state, which loads the
// result register. The second start byte reads six header bytes and walks
// the voices. A tick without a chip step waits in the output state for the
// interpolator; each chip step walks the voices through the read, wait, ROM
// (even positions only) and accumulate states, idle voices only through the
// read state, and ends in the step state. Reset clears control state and the
// mix history; voice and ROM memories are not cleared. A stalled receiver
// holds the result register; the next request is taken and runs, waiting to
// finish until the result register frees.
`timescale 1ns / 1ps
module adpcm_four_voice_sample_player_core import afvsp_pkg::*; #(
  parameter int unsigned ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
  parameter int unsigned VOICES        = VOICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  afvsp_req_if.sink   req_i,
  afvsp_res_if.source res_o,
  afvsp_cfg_if.sink   cfg_i
);

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HDR    = 4'd1;
  localparam logic [3:0] S_STARTV = 4'd2;
  localparam logic [3:0] S_VRD    = 4'd3;
  localparam logic [3:0] S_VWAIT  = 4'd4;
  localparam logic [3:0] S_VROM   = 4'd5;
  localparam logic [3:0] S_VACC   = 4'd6;
  localparam logic [3:0] S_STEP   = 4'd7;
  localparam logic [3:0] S_OUTW   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]  state_q;
  logic [VW-1:0] vcnt_q;
  logic [2:0]  hcnt_q;
  logic [47:0] hdr_q;
  logic [VOICES-1:0] active_q;
  logic        pend_q;
  logic [9:0]  phrase_q;
  logic [3:0]  sel_q, vol_q;
  logic signed [MIX_W-1:0] prev_q, cur_q, acc_q;
  logic [16:0] frac_q;
  logic [9:0]  mvol_q;
  logic [15:0] sstep_q;
  logic signed [15:0] aud_q;
  logic        res_valid_q;
  logic signed [15:0] res_audio_q;
  logic [3:0]  res_active_q;
  logic signed [11:0] dlvl_q;
  logic [8:0]  dgain_q;

  logic [7:0]  rom_mem [2**ROM_ADDR_BITS];
  logic [7:0]  rom_rd_q;
  logic        rom_we, rom_re;
  logic [ROM_ADDR_BITS-1:0] rom_addr;
  logic [23:0] addr_w;

  voice_t      vmem [VOICES];
  voice_t      vrd_q, vwdata, dec_nxt;
  logic        vwe, vre;

  logic        accept, res_free, istart;
  interp_req_t ireq;
  logic        idone;
  logic signed [15:0] isample;
  logic [24:0] hstart, hend, hspan;
  logic        hok;
  logic [16:0] frac_m1;
  logic signed [21:0] prod_w, prod_adj;
  logic [3:0]  act_ext;

  afvsp_adpcm u_adpcm (
    .cur_i      (vrd_q),
    .rom_byte_i (rom_rd_q),
    .nxt_o      (dec_nxt)
  );

  afvsp_interp u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (istart),
    .req_i    (ireq),
    .done_o   (idone),
    .sample_o (isample)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign res_free    = !res_valid_q || res_o.ready;
  assign frac_m1     = frac_q - ONE_STEP;

  always_comb begin
    hstart = {hdr_q[47:40], 17'd0} | {8'd0, hdr_q[39:32], 9'd0} | {16'd0, hdr_q[31:24], 1'b0};
    hend   = {hdr_q[23:16], 17'd0} | {8'd0, hdr_q[15:8], 9'd0} | {16'd0, hdr_q[7:0], 1'b0};
    hspan  = hend - hstart;
    hok    = (hend >= hstart) && (hspan <= 25'(SPAN_LIMIT));
    prod_w   = 22'(dlvl_q * $signed({1'b0, dgain_q}));
    prod_adj = prod_w + ((prod_w < 0) ? 22'sd15 : 22'sd0);
    act_ext  = '0;
    act_ext[VOICES-1:0] = active_q;
  end

  always_comb begin
    rom_we = accept && (req_i.req_type == REQ_ROM);
    rom_re = 1'b0;
    addr_w = 24'(req_i.rom_addr);
    if (state_q == S_HDR) begin
      rom_re = (hcnt_q < 3'd6);
      addr_w = 24'(phrase_q + 10'(hcnt_q));
    end else if (state_q == S_VWAIT) begin
      rom_re = !vrd_q.pos[0];
      addr_w = 24'(vrd_q.pos[POS_W-1:1]);
    end
    rom_addr = addr_w[ROM_ADDR_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rom_we) rom_mem[rom_addr] <= req_i.rom_byte;
    if (rom_re) rom_rd_q <= rom_mem[rom_addr];
  end

  always_comb begin
    vre    = (state_q == S_VRD) && active_q[vcnt_q];
    vwe    = 1'b0;
    vwdata = dec_nxt;
    if (state_q == S_STARTV) begin
      vwe          = sel_q[vcnt_q] && !active_q[vcnt_q] && hok;
      vwdata.pos   = hstart[POS_W-1:0];
      vwdata.rem   = hspan[POS_W-1:0];
      vwdata.sidx  = 6'd0;
      vwdata.lvl   = -12'sd1;
      vwdata.latch = 8'd0;
      vwdata.gain  = gain_lut(vol_q);
    end else if (state_q == S_VWAIT) begin
      vwe = (vrd_q.rem != '0) && vrd_q.pos[0];
    end else if (state_q == S_VROM) begin
      vwe = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vcnt_q] <= vwdata;
    if (vre) vrd_q <= vmem[vcnt_q];
    if (vwe) begin
      dlvl_q  <= dec_nxt.lvl;
      dgain_q <= dec_nxt.gain;
    end
  end

  always_comb begin
    istart    = 1'b0;
    ireq.prev = prev_q;
    ireq.cur  = cur_q;
    ireq.frac = frac_q[11:0];
    ireq.mvol = mvol_q;
    if (accept && (req_i.req_type == REQ_TICK) && (frac_q < ONE_STEP)) begin
      istart = 1'b1;
    end else if ((state_q == S_STEP) && (frac_m1 < ONE_STEP)) begin
      istart   = 1'b1;
      ireq.cur = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcnt_q      <= '0;
      hcnt_q      <= '0;
      active_q    <= '0;
      pend_q      <= 1'b0;
      phrase_q    <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      acc_q       <= '0;
      frac_q      <= '0;
      mvol_q      <= MASTER_VOLUME_RST;
      sstep_q     <= SAMPLE_STEP_RST;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_MASTER_VOLUME) mvol_q <= cfg_i.data[9:0];
        else if (cfg_i.index == CFG_SAMPLE_STEP) sstep_q <= cfg_i.data;
      end
      if (res_valid_q && res_o.ready) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            aud_q <= '0;
            state_q <= S_DONE;
            if (req_i.req_type == REQ_TICK) begin
              if (frac_q >= ONE_STEP) begin
                prev_q  <= cur_q;
                acc_q   <= '0;
                vcnt_q  <= '0;
                state_q <= S_VRD;
              end else begin
                state_q <= S_OUTW;
              end
            end else if (req_i.req_type == REQ_CMD) begin
              if (pend_q) begin
                pend_q  <= 1'b0;
                sel_q   <= req_i.cmd_byte[7:4];
                vol_q   <= req_i.cmd_byte[3:0];
                hcnt_q  <= '0;
                state_q <= S_HDR;
              end else if (req_i.cmd_byte[7]) begin
                phrase_q <= {req_i.cmd_byte[6:0], 3'd0};
                pend_q   <= 1'b1;
              end else begin
                active_q <= active_q & ~VOICES'(req_i.cmd_byte[6:3]);
              end
            end
          end
        end
        S_HDR: begin
          hcnt_q <= hcnt_q + 3'd1;
          if (hcnt_q != 3'd0) hdr_q <= {hdr_q[39:0], rom_rd_q};
          if (hcnt_q == 3'd6) begin
            vcnt_q  <= '0;
            state_q <= S_STARTV;
          end
        end
        S_STARTV: begin
          if (vwe) active_q[vcnt_q] <= 1'b1;
          if (vcnt_q == VW'(VOICES - 1)) state_q <= S_DONE;
          else vcnt_q <= vcnt_q + 1'b1;
        end
        S_VRD: begin
          if (active_q[vcnt_q]) begin
            state_q <= S_VWAIT;
          end else if (vcnt_q == VW'(VOICES - 1)) begin
            state_q <= S_STEP;
          end else begin
            vcnt_q <= vcnt_q + 1'b1;
          end
        end
        S_VWAIT: begin
          if (vrd_q.rem == '0) begin
            active_q[vcnt_q] <= 1'b0;
            if (vcnt_q == VW'(VOICES - 1)) begin
              state_q <= S_STEP;
            end else begin
              vcnt_q  <= vcnt_q + 1'b1;
              state_q <= S_VRD;
            end
          end else if (vrd_q.pos[0]) begin
            state_q <= S_VACC;
          end else begin
            state_q <= S_VROM;
          end
        end
        S_VROM: begin
          state_q <= S_VACC;
        end
        S_VACC: begin
          acc_q <= acc_q + MIX_W'(prod_adj >>> 4);
          if (vcnt_q == VW'(VOICES - 1)) begin
            state_q <= S_STEP;
          end else begin
            vcnt_q  <= vcnt_q + 1'b1;
            state_q <= S_VRD;
          end
        end
        S_STEP: begin
          cur_q  <= acc_q;
          frac_q <= frac_m1;
          if (frac_m1 >= ONE_STEP) begin
            acc_q   <= '0;
            vcnt_q  <= '0;
            state_q <= S_VRD;
          end else begin
            state_q <= S_OUTW;
          end
        end
        S_OUTW: begin
          if (idone) begin
            aud_q   <= isample;
            frac_q  <= frac_q + 17'(sstep_q);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            res_valid_q  <= 1'b1;
            res_audio_q  <= aud_q;
            res_active_q <= act_ext;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.audio_sample = res_audio_q;
  assign res_o.voice_active = res_active_q;

  a_outw_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUTW) |-> (frac_q < ONE_STEP))
    else $error("fraction not reduced before interpolation");

  a_rom_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_we |-> (state_q == S_IDLE))
    else $error("rom write outside idle");

  a_vmem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vwe && vre))
    else $error("voice memory read and write in one cycle");

  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.req_type == REQ_CMD) && pend_q) |=> (state_q == S_HDR) && !pend_q)
    else $error("second start byte did not enter header read");

endmodule

// ===== sv/afvsp_adpcm.sv =====
// ADPCM nibble decoder: level, step index, position, remaining count and latch update of one voice entry.
`timescale 1ns / 1ps
module afvsp_adpcm import afvsp_pkg::*; (
  input  voice_t     cur_i,
  input  logic [7:0] rom_byte_i,
  output voice_t     nxt_o
);

  logic [7:0]         byte_l;
  logic [3:0]         nib;
  logic [10:0]        stp;
  logic [12:0]        mag;
  logic signed [13:0] lvl_w;
  logic signed [6:0]  idx_w;

  always_comb begin
    byte_l = cur_i.pos[0] ? cur_i.latch : rom_byte_i;
    nib    = cur_i.pos[0] ? byte_l[3:0] : byte_l[7:4];
    stp    = step_size(cur_i.sidx);
    mag    = 13'(stp >> 3);
    if (nib[0]) mag = mag + 13'(stp >> 2);
    if (nib[1]) mag = mag + 13'(stp >> 1);
    if (nib[2]) mag = mag + 13'(stp);
    lvl_w  = 14'(cur_i.lvl) + (nib[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));
    idx_w  = $signed({1'b0, cur_i.sidx}) + 7'(step_adjust(nib[2:0]));
    nxt_o  = cur_i;
    nxt_o.pos   = cur_i.pos + 1'b1;
    nxt_o.rem   = cur_i.rem - 1'b1;
    nxt_o.latch = byte_l;
    if (lvl_w > LVL_MAX) begin
      nxt_o.lvl = LVL_MAX[11:0];
    end else if (lvl_w < LVL_MIN) begin
      nxt_o.lvl = LVL_MIN[11:0];
    end else begin
      nxt_o.lvl = lvl_w[11:0];
    end
    if (idx_w > IDX_MAX) begin
      nxt_o.sidx = IDX_MAX[5:0];
    end else if (idx_w < 7'sd0) begin
      nxt_o.sidx = 6'd0;
    end else begin
      nxt_o.sidx = idx_w[5:0];
    end
  end

endmodule

// ===== sv/afvsp_interp.sv =====
// Two-stage interpolation and master gain pipeline with 16-bit clipping.
`timescale 1ns / 1ps
module afvsp_interp import afvsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  interp_req_t        req_i,
  output logic               done_o,
  output logic signed [15:0] sample_o
);

  logic               v1_q, v2_q;
  logic signed [31:0] p1_q, p1_d;
  logic signed [MIX_W-1:0] prev_q;
  logic [9:0]         mvol_q;
  logic signed [31:0] p2_q, p2_d;
  logic signed [20:0] s_w;
  logic signed [23:0] o_w;

  always_comb begin
    p1_d = 32'($signed(19'(req_i.cur) - 19'(req_i.prev)) * $signed({1'b0, req_i.frac}));
    s_w  = 21'(prev_q) + 21'(p1_q >>> 12);
    p2_d = 32'(s_w * $signed({1'b0, mvol_q}));
    o_w  = 24'(p2_q >>> 8);
    if (o_w > OUT_MAX) begin
      sample_o = OUT_MAX[15:0];
    end else if (o_w < OUT_MIN) begin
      sample_o = OUT_MIN[15:0];
    end else begin
      sample_o = o_w[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p1_q   <= p1_d;
      prev_q <= req_i.prev;
      mvol_q <= req_i.mvol;
    end
    if (v1_q) p2_q <= p2_d;
  end

  assign done_o = v2_q;

endmodule

// ===== verif/adpcm_four_voice_sample_player_core_test.sv =====
// Self-checking testbench for the four-voice ADPCM sample player core.
`timescale 1ns / 1ps
module adpcm_four_voice_sample_player_core_test;
  import afvsp_pkg::*;

  localparam int ROM_BYTES  = 262144;
  localparam int STALL_MAX  = 20000;
  localparam int SETTLE     = 40;

  typedef struct {
    logic signed [15:0] audio;
    logic [3:0]         active;
  } player_out_t;

  typedef enum {PH_PLAY, PH_BACKWARD, PH_EMPTY, PH_HUGE} phrase_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  afvsp_req_if req();
  afvsp_res_if res();
  afvsp_cfg_if cfg();

  adpcm_four_voice_sample_player_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  const int step_tbl[49] = '{
    16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45, 50, 55, 60, 66,
    73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
    337, 371, 408, 449, 494, 544, 598, 658, 724, 796, 876, 963, 1060, 1166, 1282, 1411,
    1552};
  const int adj_tbl[8] = '{-1, -1, -1, -1, 2, 4, 6, 8};
  const int vol_tbl[16] = '{256, 181, 128, 91, 64, 46, 32, 23, 16, 11, 8, 6, 4, 3, 2, 1};

  bit [7:0]    rom_img [ROM_BYTES];
  bit          rom_known [ROM_BYTES];
  bit          phrase_ok [128];
  bit [18:0]   v_pos [4];
  int unsigned v_rem [4];
  int          v_sidx [4];
  int          v_lvl [4];
  bit [7:0]    v_latch [4];
  int          v_gain [4];
  bit [3:0]    act_mask;
  bit          start_pend;
  bit [9:0]    phr_addr;
  int          prev_mix, cur_mix;
  int unsigned frac, mvol, sstep;

  player_out_t audio_due[$];
  int errors = 0;
  int sent = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int stall_cnt = 0;

  function automatic int decode_nibble(int v);
    bit [3:0] nib;
    int step, mag, lvl, si;
    if (v_pos[v][0]) begin
      nib = v_latch[v][3:0];
    end else begin
      v_latch[v] = rom_img[v_pos[v][18:1]];
      nib = v_latch[v][7:4];
    end
    step = step_tbl[v_sidx[v]];
    mag = step >> 3;
    if (nib[0]) mag += step >> 2;
    if (nib[1]) mag += step >> 1;
    if (nib[2]) mag += step;
    lvl = v_lvl[v] + (nib[3] ? -mag : mag);
    if (lvl > 2047) lvl = 2047;
    if (lvl < -2048) lvl = -2048;
    v_lvl[v] = lvl;
    si = v_sidx[v] + adj_tbl[nib[2:0]];
    if (si > 48) si = 48;
    if (si < 0) si = 0;
    v_sidx[v] = si;
    v_pos[v] = v_pos[v] + 19'd1;
    return (lvl * v_gain[v]) / 16;
  endfunction

  function automatic void start_voices(bit [3:0] sel, bit [3:0] vol);
    int unsigned h [6];
    int unsigned s, e;
    for (int k = 0; k < 6; k++) h[k] = rom_img[18'(phr_addr + k)];
    s = (h[0] << 17) | (h[1] << 9) | (h[2] << 1);
    e = (h[3] << 17) | (h[4] << 9) | (h[5] << 1);
    for (int v = 0; v < 4; v++) begin
      if (!sel[v] || act_mask[v]) continue;
      if (e < s || e - s >= 32'h80000) continue;
      v_gain[v] = vol_tbl[vol];
      v_pos[v] = s[18:0];
      v_rem[v] = e - s;
      v_sidx[v] = 0;
      v_lvl[v] = -1;
      act_mask[v] = 1'b1;
    end
  endfunction

  function automatic logic signed [15:0] output_tick();
    longint s;
    int mix;
    if (frac >= 4096) begin
      prev_mix = cur_mix;
      do begin
        mix = 0;
        for (int v = 0; v < 4; v++) begin
          if (!act_mask[v]) continue;
          if (v_rem[v] == 0) begin
            act_mask[v] = 1'b0;
            continue;
          end
          v_rem[v]--;
          mix += decode_nibble(v);
        end
        cur_mix = mix;
        frac -= 4096;
      end while (frac >= 4096);
    end
    s = longint'(prev_mix) + ((longint'(cur_mix - prev_mix) * longint'(frac)) >>> 12);
    s = (s * longint'(mvol)) >>> 8;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    frac += sstep;
    return 16'(s);
  endfunction

  function automatic player_out_t advance_player(logic [1:0] t, logic [7:0] c,
                                                 logic [17:0] a, logic [7:0] b);
    player_out_t r;
    r.audio = '0;
    case (t)
      REQ_TICK: r.audio = output_tick();
      REQ_CMD: begin
        if (start_pend) begin
          start_pend = 1'b0;
          start_voices(c[7:4], c[3:0]);
        end else if (c[7]) begin
          phr_addr = {c[6:0], 3'b000};
          start_pend = 1'b1;
        end else begin
          act_mask &= ~c[6:3];
        end
      end
      REQ_ROM: begin
        rom_img[a] = b;
        rom_known[a] = 1'b1;
      end
      default: ;
    endcase
    r.active = act_mask;
    return r;
  endfunction

  task automatic send_req(logic [1:0] t, logic [7:0] c, logic [17:0] a, logic [7:0] b);
    @(negedge clk_i);
    if ($urandom_range(99) < snd_idle_pct) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.req_type = t;
    req.cmd_byte = c;
    req.rom_addr = a;
    req.rom_byte = b;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    audio_due.push_back(advance_player(t, c, a, b));
    sent++;
  endtask

  task automatic rom_write(logic [17:0] a, logic [7:0] b);
    send_req(REQ_ROM, $urandom, a, b);
  endtask

  task automatic command(logic [7:0] c);
    send_req(REQ_CMD, c, $urandom, $urandom);
  endtask

  task automatic tick(int n = 1);
    repeat (n) send_req(REQ_TICK, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid = 1'b0;
    while (audio_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    if (idx == CFG_MASTER_VOLUME) mvol = val[9:0];
    else if (idx == CFG_SAMPLE_STEP) sstep = val;
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic make_phrase(int p, phrase_kind_e kind, int sb, int len);
    int unsigned s, e;
    bit [7:0] h [6];
    s = sb * 2 + (($urandom_range(3) == 0) ? $urandom_range(1, 31) * 32'h80000 : 0);
    case (kind)
      PH_PLAY:     e = s + 2 * len;
      PH_BACKWARD: e = s - 2;
      PH_EMPTY:    e = s;
      default:     e = s + 32'h80000;
    endcase
    if (kind == PH_PLAY) begin
      for (int i = 0; i < len; i++) begin
        if (!rom_known[18'(sb + i)]) rom_write(18'(sb + i), $urandom);
      end
    end
    h = '{8'(s >> 17), 8'(s >> 9), 8'(s >> 1), 8'(e >> 17), 8'(e >> 9), 8'(e >> 1)};
    for (int k = 0; k < 6; k++) rom_write(18'(p * 8 + k), h[k]);
    phrase_ok[p] = 1'b1;
  endtask

  task automatic start_phrase(int p, bit [3:0] sel, bit [3:0] vol);
    command({1'b1, 7'(p)});
    command({sel, vol});
  endtask

  task automatic test_plain_requests();
    rom_write(18'h00000, 8'h00);
    rom_write(18'h3ffff, 8'hff);
    send_req(REQ_NONE, 8'hff, 18'h3ffff, 8'hff);
    command(8'h7f);
    command(8'h00);
    tick(2);
  endtask

  task automatic test_voice_starts();
    make_phrase(1, PH_PLAY, ROM_BYTES - 3, 6);
    start_phrase(1, 4'b1111, 4'd0);
    start_phrase(1, 4'b0001, 4'd15);
    tick(4);
    command(8'h08);
    tick(2);
    command(8'h78);
    make_phrase(2, PH_BACKWARD, 2000, 0);
    start_phrase(2, 4'b1111, 4'd3);
    make_phrase(3, PH_EMPTY, 3000, 0);
    start_phrase(3, 4'b0100, 4'd7);
    make_phrase(4, PH_HUGE, 4000, 0);
    start_phrase(4, 4'b1000, 4'd9);
    tick(3);
    make_phrase(127, PH_PLAY, 5000, 40);
    start_phrase(127, 4'b1010, 4'd15);
    tick(30);
    drain();
  endtask

  task automatic test_config_extremes();
    cfg_write(CFG_MASTER_VOLUME, 16'd1023);
    cfg_write(CFG_SAMPLE_STEP, 16'hffff);
    start_phrase(127, 4'b1111, 4'd0);
    tick(8);
    drain();
    cfg_write(CFG_MASTER_VOLUME, 16'd0);
    cfg_write(CFG_SAMPLE_STEP, 16'd0);
    start_phrase(1, 4'b0011, 4'd1);
    tick(4);
    drain();
    cfg_write(CFG_SAMPLE_STEP, 16'd4096);
    tick(10);
    drain();
  endtask

  task automatic random_item();
    int p, r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 45) begin
      tick($urandom_range(1, 3));
    end else if (r < 72) begin
      if (start_pend) command($urandom);
      p = $urandom_range(127);
      if (!phrase_ok[p] || $urandom_range(3) == 0)
        make_phrase(p, ($urandom_range(9) == 0) ? phrase_kind_e'($urandom_range(1, 3)) : PH_PLAY,
                    $urandom_range(1024, ROM_BYTES - 1), $urandom_range(1, 48));
      start_phrase(p, $urandom, $urandom);
    end else if (r < 78) begin
      command({1'b0, 7'($urandom)});
    end else if (r < 88) begin
      c = $urandom;
      if (!start_pend && c[7] && !phrase_ok[c[6:0]])
        make_phrase(c[6:0], PH_PLAY, $urandom_range(1024, ROM_BYTES - 1), $urandom_range(1, 48));
      command(c);
    end else if (r < 95) begin
      rom_write(18'($urandom_range(1024, ROM_BYTES - 1)), $urandom);
    end else begin
      send_req(REQ_NONE, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_random_traffic(int n, int snd, int rcv);
    int stop_at;
    int half_at;
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    stop_at = sent + n;
    half_at = sent + n / 2;
    cfg_write(CFG_MASTER_VOLUME, $urandom_range(1023));
    cfg_write(CFG_SAMPLE_STEP, ($urandom_range(7) == 0) ? $urandom : $urandom_range(512, 20000));
    while (sent < half_at) random_item();
    drain();
    while (sent < stop_at) random_item();
    drain();
  endtask

  always @(negedge clk_i) begin
    res.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    player_out_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (audio_due.size() == 0) begin
        $display("%0t: unexpected result audio=%0d active=%h", $time,
                 res.audio_sample, res.voice_active);
        errors++;
      end else begin
        want = audio_due.pop_front();
        if (res.audio_sample !== want.audio) begin
          $display("%0t: audio_sample expected %0d actual %0d", $time,
                   want.audio, res.audio_sample);
          errors++;
        end
        if (res.voice_active !== want.active) begin
          $display("%0t: voice_active expected %h actual %h", $time,
                   want.active, res.voice_active);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == STALL_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_TICK;
    req.cmd_byte = '0;
    req.rom_addr = '0;
    req.rom_byte = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_MASTER_VOLUME;
    cfg.data = '0;
    res.ready = 1'b0;
    mvol = MASTER_VOLUME_RST;
    sstep = SAMPLE_STEP_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_plain_requests();
    test_voice_starts();
    test_config_extremes();
    test_random_traffic(630, 38, 84);
    test_random_traffic(630, 84, 38);
    test_random_traffic(630, 0, 0);
    if (audio_due.size() != 0) begin
      $display("%0t: %0d results missing", $time, audio_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
